// File: rtl/pccb_pkg.sv
package pccb_pkg;

  localparam int unsigned BinW     = 23;
  localparam int unsigned Bins     = 256;
  localparam int unsigned BinAw    = 8;
  localparam int unsigned Chans    = 3;
  localparam int unsigned HistDepth = 1024;
  localparam int unsigned HistAw   = 10;
  localparam int unsigned PctW     = 14;
  localparam int unsigned MaxPixels = 4194304;
  localparam int unsigned FullScale = 20000;
  localparam logic [PctW-1:0] PctReset = 14'd100;

  // command codes
  localparam logic CMD_HIST = 1'b0;
  localparam logic CMD_CORR = 1'b1;

  // register indexes
  localparam logic [0:0] REG_CLIP = 1'b0;

  // controller to datapath
  typedef struct packed {
    logic       hist_rd;     // read bins of the pixel (count phase, first beat)
    logic       hist_wr;     // write back incremented bins
    logic       hist_clr;    // zero one bin of every channel after reset
    logic       rank_start;  // invalidate rank limits
    logic       rank_step;   // load scaled rank limits from total
    logic       walk_clr;    // reset walk accumulators
    logic       walk_rd;     // read walk address
    logic       walk_acc;    // accumulate read data
    logic [BinAw+1:0] walk_addr; // {chan, bin}
    logic       walk_done_ch;// latch bounds of channel
    logic       total_clr;
    logic       corr_load;   // load correction operands
    logic       corr_step;   // one divider step
    logic       corr_fin;    // finish rounding, load output
  } pccb_cmd_t;

  typedef struct packed {
    logic       full;
    logic       div_done;
    logic       corr_done;
  } pccb_sts_t;

endpackage

// File: rtl/pccb_ram.sv
module pccb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pccb_datapath.sv
module pccb_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pccb_pkg::pccb_cmd_t       ctl,
  output pccb_pkg::pccb_sts_t       sts,
  input  logic [pccb_pkg::PctW-1:0] clip_pct,
  input  logic [7:0]                pix_r,
  input  logic [7:0]                pix_g,
  input  logic [7:0]                pix_b,
  output logic [7:0]                res_r,
  output logic [7:0]                res_g,
  output logic [7:0]                res_b
);

  localparam int unsigned BW = pccb_pkg::BinW;

  // histogram memories, one per channel
  logic [BW-1:0] rd [3];
  logic [7:0]    px [3];
  logic [7:0]    addr [3];
  logic          we;
  logic [BW-1:0] wd [3];
  logic [BW-1:0] total_r, total_nxt;

  assign px[0] = pix_r;
  assign px[1] = pix_g;
  assign px[2] = pix_b;

  genvar gi;
  generate
    for (gi = 0; gi < 3; gi++) begin : g_hist
      always_comb begin
        if (ctl.walk_rd || ctl.hist_clr || ctl.hist_wr && !ctl.hist_rd) begin
          addr[gi] = ctl.hist_wr ? px[gi] : ctl.walk_addr[7:0];
        end else begin
          addr[gi] = px[gi];
        end
      end
      // bins are cleared by writing zero during the walk and after reset
      assign wd[gi] = (ctl.walk_rd || ctl.hist_clr) ? '0 : rd[gi] + BW'(1);
      pccb_ram #(.Width(BW), .Depth(pccb_pkg::Bins)) u_ram (
        .clk  (clk),
        .we   (we && (!ctl.walk_rd || ctl.walk_addr[9:8] == 2'(gi))),
        .waddr(addr[gi]),
        .wdata(wd[gi]),
        .raddr(addr[gi]),
        .rdata(rd[gi])
      );
    end
  endgenerate

  assign we = ctl.hist_wr || ctl.walk_rd || ctl.hist_clr;

  // pixel count
  always_comb begin
    total_nxt = total_r;
    if (ctl.total_clr) begin
      total_nxt = '0;
    end else if (ctl.hist_wr) begin
      total_nxt = total_r + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  assign sts.full = (24'(total_r) >= 24'(pccb_pkg::MaxPixels));

  // rank limits kept scaled by 20000: cum > floor(x/20000) iff cum*20000 > x
  logic [37:0] lo_lim_r, hi_lim_r;
  logic        lim_ok_r;
  logic [37:0] prod_lo, prod_hi;

  assign prod_lo = 38'(total_r) * 38'(clip_pct);
  assign prod_hi = 38'(total_r) * 38'(15'(pccb_pkg::FullScale) - 15'(clip_pct))
                   + 38'(pccb_pkg::FullScale - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_ok_r <= 1'b0;
    end else if (ctl.rank_start) begin
      lim_ok_r <= 1'b0;
    end else if (ctl.rank_step) begin
      lim_ok_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rank_step) begin
      lo_lim_r <= prod_lo;
      hi_lim_r <= prod_hi;
    end
  end

  assign sts.div_done = lim_ok_r;

  // walk: cumulative sum per channel
  logic [BW:0]  cum_r;
  logic [7:0]   lo_v_r, hi_v_r;
  logic         lo_f_r, hi_f_r;
  logic [1:0]   wch_r;
  logic [7:0]   wbin_r;
  logic [BW-1:0] rsel;
  logic [BW:0]  cum_nxt;
  logic [37:0]  cum_sc;
  logic [7:0]   lo_b_r [3];
  logic [7:0]   hi_b_r [3];

  always_comb begin
    unique case (wch_r)
      2'd0:    rsel = rd[0];
      2'd1:    rsel = rd[1];
      default: rsel = rd[2];
    endcase
  end
  assign cum_nxt = cum_r + (BW+1)'(rsel);
  assign cum_sc  = 38'(cum_nxt) * 38'(pccb_pkg::FullScale);

  always_ff @(posedge clk) begin
    wch_r  <= ctl.walk_addr[9:8];
    wbin_r <= ctl.walk_addr[7:0];
    if (ctl.walk_clr) begin
      cum_r  <= '0;
      lo_f_r <= 1'b0;
      hi_f_r <= 1'b0;
      lo_v_r <= 8'd255;
      hi_v_r <= 8'd255;
    end else if (ctl.walk_acc) begin
      cum_r <= cum_nxt;
      if (!lo_f_r && cum_sc > lo_lim_r) begin
        lo_f_r <= 1'b1;
        lo_v_r <= wbin_r;
      end
      // high rank clamped to n-1
      if (!hi_f_r && (cum_sc > hi_lim_r || cum_nxt >= (BW+1)'(total_r))) begin
        hi_f_r <= 1'b1;
        hi_v_r <= wbin_r;
      end
    end
  end

  // bounds; kept unchanged when no pixel was counted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        lo_b_r[c] <= 8'd0;
        hi_b_r[c] <= 8'd255;
      end
    end else if (ctl.walk_done_ch && total_r != '0) begin
      lo_b_r[wch_r] <= lo_v_r;
      hi_b_r[wch_r] <= hi_v_r;
    end
  end

  // correction: clip, then bit-serial divide of (v-lo)*255 by (hi-lo)
  logic [15:0] num_r [3];
  logic [7:0]  den_r [3];
  logic [8:0]  rem_r [3];
  logic [15:0] q_r [3];
  logic        zero_r [3];
  logic [4:0]  ccnt_r;
  logic [7:0]  res_r_a [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccnt_r <= '0;
    end else if (ctl.corr_load) begin
      ccnt_r <= 5'd16;
    end else if (ctl.corr_step && ccnt_r != '0) begin
      ccnt_r <= ccnt_r - 5'd1;
    end
  end
  assign sts.corr_done = (ccnt_r == '0);

  generate
    for (gi = 0; gi < 3; gi++) begin : g_corr
      logic [7:0] cv;
      logic [8:0] tr;
      logic [9:0] r2;
      logic [15:0] qr;
      always_comb begin
        cv = px[gi];
        if (cv < lo_b_r[gi]) cv = lo_b_r[gi];
        if (cv > hi_b_r[gi]) cv = hi_b_r[gi];
        tr = {rem_r[gi][7:0], q_r[gi][15]};
        r2 = {rem_r[gi], 1'b0};
        if (r2 > 10'(den_r[gi]) || (r2 == 10'(den_r[gi]) && q_r[gi][0])) begin
          qr = q_r[gi] + 16'd1;
        end else begin
          qr = q_r[gi];
        end
      end
      always_ff @(posedge clk) begin
        if (ctl.corr_load) begin
          zero_r[gi] <= (hi_b_r[gi] <= lo_b_r[gi]);
          q_r[gi]    <= 16'(cv - lo_b_r[gi]) * 16'd255;
          den_r[gi]  <= hi_b_r[gi] - lo_b_r[gi];
          rem_r[gi]  <= '0;
        end else if (ctl.corr_step && ccnt_r != '0) begin
          if (tr >= 9'(den_r[gi])) begin
            rem_r[gi] <= tr - 9'(den_r[gi]);
            q_r[gi]   <= {q_r[gi][14:0], 1'b1};
          end else begin
            rem_r[gi] <= tr;
            q_r[gi]   <= {q_r[gi][14:0], 1'b0};
          end
        end
        if (ctl.corr_fin) begin
          if (zero_r[gi]) begin
            res_r_a[gi] <= 8'd0;
          end else begin
            res_r_a[gi] <= (qr > 16'd255) ? 8'd255 : qr[7:0];
          end
        end
      end
    end
  endgenerate

  assign res_r = res_r_a[0];
  assign res_g = res_r_a[1];
  assign res_b = res_r_a[2];

endmodule

// File: rtl/pccb_ctrl.sv
module pccb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic                last_pixel,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_last,
  output pccb_pkg::pccb_cmd_t ctl,
  input  pccb_pkg::pccb_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INC  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_CORR = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic [2:0] S_CLR  = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic        cmd_r, last_r;
  logic [10:0] wcnt_r, wcnt_nxt;  // {chan, bin} plus one pipeline tail
  logic        acc_r;
  logic        chan_end;
  logic        chan_end_d;
  logic        accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_last  = last_r;
  assign chan_end  = (wcnt_r[7:0] == 8'd255);

  // next state
  always_comb begin
    state_nxt = state_r;
    wcnt_nxt  = wcnt_r;
    unique case (state_r)
      S_CLR: begin
        wcnt_nxt = wcnt_r + 11'd1;
        if (chan_end) begin
          wcnt_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (cmd == pccb_pkg::CMD_CORR) begin
            state_nxt = S_CORR;
          end else if (sts.full) begin
            state_nxt = last_pixel ? S_DIV : S_IDLE;
          end else begin
            state_nxt = S_INC;
          end
        end
      end
      S_INC:  state_nxt = last_r ? S_DIV : S_IDLE;
      S_DIV: begin
        wcnt_nxt = '0;
        if (sts.div_done && !ctl.rank_start) state_nxt = S_WALK;
      end
      S_WALK: begin
        wcnt_nxt = wcnt_r + 11'd1;
        if (wcnt_r == 11'd769) state_nxt = S_IDLE;
      end
      S_CORR: if (sts.corr_done && !ctl.corr_load) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // walk: one bin per beat, channels back to back with no gap
  logic walking;
  assign walking = (state_r == S_WALK) && wcnt_r < 11'd768;

  always_comb begin
    ctl = '0;
    ctl.hist_rd    = accept && cmd == pccb_pkg::CMD_HIST && !sts.full;
    ctl.hist_wr    = (state_r == S_INC);
    ctl.hist_clr   = (state_r == S_CLR);
    ctl.rank_start = (state_r != S_DIV) && (state_nxt == S_DIV);
    ctl.rank_step  = (state_r == S_DIV);
    ctl.walk_rd    = walking;
    ctl.walk_addr  = {wcnt_r[9:8], wcnt_r[7:0]};
    ctl.walk_acc   = acc_r;
    ctl.walk_clr   = (state_r == S_DIV) || (acc_r && chan_end_d);
    ctl.walk_done_ch = acc_r && chan_end_d;
    ctl.total_clr  = (state_r == S_WALK) && wcnt_r == 11'd769;
    ctl.corr_load  = accept && cmd == pccb_pkg::CMD_CORR;
    ctl.corr_step  = (state_r == S_CORR);
    ctl.corr_fin   = (state_r == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      wcnt_r     <= '0;
      acc_r      <= 1'b0;
      chan_end_d <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wcnt_r     <= wcnt_nxt;
      acc_r      <= walking;
      chan_end_d <= walking && chan_end;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd;
      last_r <= last_pixel;
    end
  end

  // a result only follows a correction pixel
  a_out_corr: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> cmd_r == pccb_pkg::CMD_CORR)
    else $error("result without correction pixel");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !(cmd == pccb_pkg::CMD_HIST && sts.full && !last_pixel) |=> !in_ready)
    else $error("accept while busy");
  a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.walk_done_ch |-> acc_r)
    else $error("channel end outside walk");

endmodule

// File: rtl/percentile_clip_color_balance_core.sv
// Two-pass colour balance. After reset the block zeroes the histogram RAMs
// and takes no pixel meanwhile. Histogram pixels (cmd 0) read-modify-write the
// three 256-bin histogram RAMs, or skip that once the frame is full; the last
// one starts a threshold pass that loads the rank limits and then walks the
// bins, which also clears them. Correction pixels (cmd 1) go through a 16-step
// bit-serial divider, plus the output handshake; one pixel is in flight at a
// time. clip_percent at byte address 0.
module percentile_clip_color_balance_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        in_last_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  pccb_pkg::pccb_cmd_t ctl;
  pccb_pkg::pccb_sts_t sts;
  logic [pccb_pkg::PctW-1:0] clip_r;
  logic [7:0] pr_r, pg_r, pb_r;

  // configuration register
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= pccb_pkg::PctReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr[1:1] == pccb_pkg::REG_CLIP) begin
      clip_r <= cfg_pwdata[pccb_pkg::PctW-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[1:1] == pccb_pkg::REG_CLIP) ?
                      32'(clip_r) : 32'd0;

  // pixel held for the multi-cycle operations
  logic acc;
  assign acc = in_valid && in_ready;
  always_ff @(posedge clk) begin
    if (acc) begin
      pr_r <= in_red;
      pg_r <= in_green;
      pb_r <= in_blue;
    end
  end

  pccb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (in_cmd),
    .last_pixel(in_last_pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_last  (out_last),
    .ctl       (ctl),
    .sts       (sts)
  );

  pccb_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .sts     (sts),
    .clip_pct(clip_r),
    .pix_r   (acc ? in_red : pr_r),
    .pix_g   (acc ? in_green : pg_r),
    .pix_b   (acc ? in_blue : pb_r),
    .res_r   (out_red),
    .res_g   (out_green),
    .res_b   (out_blue)
  );

endmodule

// File: verif/percentile_clip_color_balance_core_test.sv
`timescale 1ns / 100ps

module percentile_clip_color_balance_core_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = pccb_pkg::CMD_HIST;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic        in_last_pixel = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red, out_green, out_blue;
  logic        out_last;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  percentile_clip_color_balance_core dut (.*);

  always #5 clk = ~clk;

  // model state
  int unsigned hist_bins [3][256];
  int unsigned pixel_count;
  logic [7:0]  lo_bound [3];
  logic [7:0]  hi_bound [3];
  logic [13:0] clip_pct;
  pixel_t      balanced_q [$];
  int          errors = 0;
  int          burst_left = 0;

  function automatic logic [7:0] rank_lookup(int c, longint unsigned k);
    longint unsigned cum = 0;
    for (int v = 0; v < 256; v++) begin
      cum += hist_bins[c][v];
      if (cum > k) return 8'(v);
    end
    return 8'd255;
  endfunction

  // threshold walk at the end of a histogram frame
  function automatic void find_bounds();
    longint unsigned n = pixel_count;
    longint unsigned p = clip_pct;
    longint unsigned lo_rank, hi_rank;
    if (n != 0) begin
      lo_rank = (n * p) / pccb_pkg::FullScale;
      hi_rank = (n * (pccb_pkg::FullScale - p) + pccb_pkg::FullScale - 1)
                / pccb_pkg::FullScale;
      if (hi_rank > n - 1) hi_rank = n - 1;
      for (int c = 0; c < 3; c++) begin
        lo_bound[c] = rank_lookup(c, lo_rank);
        hi_bound[c] = rank_lookup(c, hi_rank);
      end
    end
    for (int c = 0; c < 3; c++)
      for (int v = 0; v < 256; v++) hist_bins[c][v] = 0;
    pixel_count = 0;
  endfunction

  // clip and stretch, round half to even
  function automatic logic [7:0] balance_sample(int c, logic [7:0] s);
    int unsigned lo = lo_bound[c], hi = hi_bound[c], v = s;
    int unsigned num, den, q, r;
    if (hi <= lo) return 8'd0;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    num = (v - lo) * 255;
    den = hi - lo;
    q = num / den;
    r = num % den;
    if (2 * r > den || (2 * r == den && q[0])) q++;
    return (q > 255) ? 8'd255 : 8'(q);
  endfunction

  function automatic void accept_pixel(logic cmd, logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b, logic last);
    pixel_t e;
    if (cmd == pccb_pkg::CMD_HIST) begin
      if (pixel_count < pccb_pkg::MaxPixels) begin
        hist_bins[0][r]++;
        hist_bins[1][g]++;
        hist_bins[2][b]++;
        pixel_count++;
      end
      if (last) find_bounds();
    end else begin
      e.red = balance_sample(0, r);
      e.green = balance_sample(1, g);
      e.blue = balance_sample(2, b);
      e.last = last;
      balanced_q.push_back(e);
    end
  endfunction

  // send one pixel beat, with bursts and gaps
  task automatic send_pixel(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_last_pixel <= last;
    do @(posedge clk); while (!in_ready);
    accept_pixel(cmd, r, g, b, last);
  endtask

  task automatic send_random(logic cmd, logic last);
    send_pixel(cmd, 8'($urandom), 8'($urandom), 8'($urandom), last);
  endtask

  // drain results and let any threshold walk finish, then write clip_percent
  task automatic set_clip(logic [13:0] pct);
    in_valid <= 1'b0;
    while (balanced_q.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 2'(4 * pccb_pkg::REG_CLIP);
    cfg_pwdata <= 32'($urandom) & ~32'h3fff | 32'(pct);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    clip_pct = pct;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic hist_frame(int n);
    for (int i = 0; i < n; i++) send_random(pccb_pkg::CMD_HIST, i == n - 1);
  endtask

  task automatic corr_frame(int n);
    for (int i = 0; i < n; i++) send_random(pccb_pkg::CMD_CORR, i == n - 1);
  endtask

  // result checking with a stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_valid && out_ready) begin
      if (balanced_q.size() == 0) begin
        $display("%0t: unexpected result %h %h %h %b", $time,
                 out_red, out_green, out_blue, out_last);
        errors++;
      end else begin
        e = balanced_q.pop_front();
        if (out_red !== e.red) begin
          $display("%0t: red expected %h actual %h", $time, e.red, out_red);
          errors++;
        end
        if (out_green !== e.green) begin
          $display("%0t: green expected %h actual %h", $time, e.green, out_green);
          errors++;
        end
        if (out_blue !== e.blue) begin
          $display("%0t: blue expected %h actual %h", $time, e.blue, out_blue);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t: last expected %b actual %b", $time, e.last, out_last);
          errors++;
        end
      end
    end
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic test_reset_bounds();
    // reset bounds pass values straight through
    send_pixel(pccb_pkg::CMD_CORR, 8'd0, 8'd255, 8'd128, 1'b0);
    send_pixel(pccb_pkg::CMD_CORR, 8'd255, 8'd0, 8'd1, 1'b1);
  endtask

  task automatic test_extremes();
    // single pixel frame gives equal bounds
    send_pixel(pccb_pkg::CMD_HIST, 8'd77, 8'd0, 8'd255, 1'b1);
    send_pixel(pccb_pkg::CMD_CORR, 8'd0, 8'd255, 8'd77, 1'b1);
    // two-level frame, full stretch
    send_pixel(pccb_pkg::CMD_HIST, 8'd0, 8'd255, 8'd10, 1'b0);
    send_pixel(pccb_pkg::CMD_HIST, 8'd255, 8'd0, 8'd20, 1'b1);
    send_pixel(pccb_pkg::CMD_CORR, 8'd0, 8'd255, 8'd15, 1'b0);
    send_pixel(pccb_pkg::CMD_CORR, 8'd255, 8'd0, 8'd5, 1'b0);
    send_pixel(pccb_pkg::CMD_CORR, 8'd128, 8'd127, 8'd30, 1'b1);
    hist_frame(8);
    corr_frame(6);
  endtask

  task automatic test_clip_settings();
    logic [13:0] pcts [6] = '{14'd1, 14'd9999, 14'd0, 14'd16383, 14'd10000, 14'd5000};
    foreach (pcts[i]) begin
      set_clip(pcts[i]);
      hist_frame(12);
      corr_frame(6);
    end
  endtask

  task automatic test_random();
    int sent = 0;
    int n;
    while (sent < 1600) begin
      if ($urandom_range(0, 9) == 0)
        set_clip($urandom_range(0, 5) == 0 ? 14'($urandom) : 14'($urandom_range(1, 9999)));
      case ($urandom_range(0, 9))
        0: begin
          // noise: mixed commands and marks
          n = $urandom_range(1, 10);
          for (int i = 0; i < n; i++) send_random(1'($urandom), 1'($urandom));
        end
        default: begin
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
          hist_frame(n);
          sent += n;
          n = $urandom_range(1, 20);
          corr_frame(n);
        end
      endcase
      sent += n;
    end
  endtask

  initial begin
    for (int c = 0; c < 3; c++) begin
      lo_bound[c] = 8'd0;
      hi_bound[c] = 8'd255;
      for (int v = 0; v < 256; v++) hist_bins[c][v] = 0;
    end
    pixel_count = 0;
    clip_pct = pccb_pkg::PctReset;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_clip(14'd100);
    test_reset_bounds();
    test_extremes();
    test_clip_settings();
    test_random();
    in_valid <= 1'b0;
    while (balanced_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
